// ===== design/fcs_pkg.sv =====
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared types, constants and character functions of the file-name sanitizer.
// ----------------------------------------------------------------------------
package fcs_pkg;

  localparam int unsigned PENDING_DEPTH_DEF = 32;
  localparam int unsigned CP_W              = 21;
  localparam int unsigned TDATA_W           = 24;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned CFG_DATA_W        = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SUB_LEVEL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIX_EMPTY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_TAIL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIX_RESERVED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COLON   = 3'd4;

  localparam logic [CP_W-1:0] CH_US    = 21'h00005F;
  localparam logic [CP_W-1:0] CH_DOT   = 21'h00002E;
  localparam logic [CP_W-1:0] CH_SP    = 21'h000020;
  localparam logic [CP_W-1:0] CH_QUOTE = 21'h000022;

  localparam int unsigned NUM_DEV = 6;
  // device names, one char per byte from the top; '9' stands for any digit
  localparam logic [31:0] DEV_PAT [NUM_DEV] = '{"CON ", "PRN ", "AUX ", "NUL ",
                                                "COM9", "LPT9"};
  localparam logic [2:0]  DEV_LEN [NUM_DEV] = '{3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4};

  typedef enum logic [1:0] {
    SRC_UNDERSCORE,
    SRC_CHAR,
    SRC_STORE,
    SRC_END
  } emit_src_e;

  typedef struct packed {
    logic      load;
    logic      emit;
    emit_src_e src;
    logic      push;
    logic      match;
    logic      set_done;
    logic      rel_start;
    logic      rel_trim;
    logic      rel_ovf;
    logic      rd;
    logic      flush;
  } dp_cmd_t;

  typedef struct packed {
    logic       has;
    logic       last;
    logic       open;
    logic       fix_reserved;
    logic       strip_tail;
    logic       fix_empty;
    logic       full;
    logic       cnt_zero;
    logic       body_zero;
    logic       rem_zero;
    logic       s_dotsp;
    logic [1:0] res;
    logic       res_tail;
    logic       emitted_any;
    logic       emitted_step;
    logic       emit_ok;
    logic       stage_full;
    logic       out_free;
  } dp_status_t;

  function automatic logic is_dotsp(input logic [CP_W-1:0] c);
    return (c == CH_DOT) || (c == CH_SP);
  endfunction

  // look-alike symbols for control codes 1..31
  function automatic logic [15:0] ctl_sym(input logic [4:0] i);
    logic [15:0] r;
    case (i)
      5'd1:  r = 16'h263A;  5'd2:  r = 16'h263B;  5'd3:  r = 16'h2665;
      5'd4:  r = 16'h2666;  5'd5:  r = 16'h2663;  5'd6:  r = 16'h2660;
      5'd7:  r = 16'h2022;  5'd8:  r = 16'h25D8;  5'd9:  r = 16'h25CB;
      5'd10: r = 16'h25D9;  5'd11: r = 16'h2642;  5'd12: r = 16'h2640;
      5'd13: r = 16'h266A;  5'd14: r = 16'h266B;  5'd15: r = 16'h263C;
      5'd16: r = 16'h25BA;  5'd17: r = 16'h25C4;  5'd18: r = 16'h2195;
      5'd19: r = 16'h203C;  5'd20: r = 16'h00B6;  5'd21: r = 16'h00A7;
      5'd22: r = 16'h25AC;  5'd23: r = 16'h21A8;  5'd24: r = 16'h2191;
      5'd25: r = 16'h2193;  5'd26: r = 16'h2192;  5'd27: r = 16'h2190;
      5'd28: r = 16'h221F;  5'd29: r = 16'h2194;  5'd30: r = 16'h25B2;
      5'd31: r = 16'h25BC;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  function automatic logic [CP_W-1:0] subst(input logic [CP_W-1:0] c,
                                            input logic [1:0] lvl,
                                            input logic keep,
                                            input logic qph);
    logic            sym;
    logic [CP_W-1:0] r;
    sym = lvl[1];
    r   = c;
    if (lvl != 2'd0) begin
      case (c)
        21'h3C: r = sym ? 21'h00AB : CH_US;
        21'h3E: r = sym ? 21'h00BB : CH_US;
        21'h3A: if (!keep) r = sym ? ((lvl == 2'd2) ? 21'h2026 : 21'h0589) : CH_US;
        21'h2A: r = sym ? ((lvl == 2'd2) ? 21'h00A4 : 21'h0589) : CH_US;
        21'h3F: r = sym ? 21'h00BF : CH_US;
        21'h7C: r = sym ? 21'h00A6 : CH_US;
        21'h22: r = sym ? (qph ? 21'h201D : 21'h201C) : CH_US;
        21'h2F: r = sym ? 21'h2044 : CH_US;
        21'h5C: r = sym ? 21'h00AC : CH_US;
        default: begin
          if (c >= 21'd1 && c < 21'd32) r = sym ? {5'd0, ctl_sym(c[4:0])} : CH_US;
        end
      endcase
    end
    return r;
  endfunction

  // one position of a device name against one character
  function automatic logic pat_ok(input int unsigned p, input logic [1:0] pos,
                                  input logic [CP_W-1:0] s);
    logic [CP_W-1:0] u;
    logic [7:0]      w;
    logic            ok;
    u = (s >= 21'h61 && s <= 21'h7A) ? s - 21'h20 : s;
    w = DEV_PAT[p][8*(3-pos) +: 8];
    if (w == "9") ok = (s >= 21'h30) && (s <= 21'h39);
    else          ok = (u == {13'd0, w});
    return ok;
  endfunction

endpackage

// ===== design/fcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcs_ctrl
// Sequencer: walks each item through hold, release and emit steps.
// ----------------------------------------------------------------------------
module fcs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fcs_pkg::dp_status_t  st_i,
  output fcs_pkg::dp_cmd_t     cmd_o
);
  import fcs_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_PUSH_O = 4'd2;
  localparam logic [3:0] S_RES    = 4'd3;
  localparam logic [3:0] S_US_R   = 4'd4;
  localparam logic [3:0] S_CPART  = 4'd5;
  localparam logic [3:0] S_PUSH_C = 4'd6;
  localparam logic [3:0] S_EMIT_S = 4'd7;
  localparam logic [3:0] S_LAST   = 4'd8;
  localparam logic [3:0] S_US_L   = 4'd9;
  localparam logic [3:0] S_EMPTY  = 4'd10;
  localparam logic [3:0] S_US_E   = 4'd11;
  localparam logic [3:0] S_END    = 4'd12;
  localparam logic [3:0] S_FIN    = 4'd13;
  localparam logic [3:0] S_REL_RD = 4'd14;
  localparam logic [3:0] S_REL_EM = 4'd15;

  logic [3:0] state_q, state_d;
  logic [3:0] ret_q, ret_d;
  logic [3:0] after_has;

  assign in_ready_o = (state_q == S_IDLE);
  assign after_has  = st_i.last ? S_LAST : S_FIN;

  always_comb begin
    cmd_o     = '0;
    cmd_o.src = SRC_UNDERSCORE;
    state_d   = state_q;
    ret_d     = ret_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        if (!st_i.has) begin
          state_d = after_has;
        end else if (st_i.open && !st_i.fix_reserved) begin
          cmd_o.set_done  = 1'b1;
          cmd_o.rel_start = 1'b1;
          cmd_o.rel_trim  = st_i.strip_tail;
          if (st_i.strip_tail ? st_i.body_zero : st_i.cnt_zero) begin
            state_d = S_CPART;
          end else begin
            state_d = S_REL_RD;
            ret_d   = S_CPART;
          end
        end else if (st_i.open && st_i.full) begin
          cmd_o.set_done  = 1'b1;
          cmd_o.rel_start = 1'b1;
          cmd_o.rel_ovf   = 1'b1;
          state_d         = S_REL_RD;
          ret_d           = S_CPART;
        end else if (st_i.open) begin
          state_d = S_PUSH_O;
        end else if (st_i.strip_tail && st_i.s_dotsp) begin
          if (st_i.full) begin
            cmd_o.rel_start = 1'b1;
            cmd_o.rel_ovf   = 1'b1;
            state_d         = S_REL_RD;
            ret_d           = S_PUSH_C;
          end else begin
            state_d = S_PUSH_C;
          end
        end else begin
          cmd_o.rel_start = 1'b1;
          if (st_i.cnt_zero) begin
            state_d = S_EMIT_S;
          end else begin
            state_d = S_REL_RD;
            ret_d   = S_EMIT_S;
          end
        end
      end
      S_PUSH_O: begin
        cmd_o.push  = 1'b1;
        cmd_o.match = 1'b1;
        state_d     = S_RES;
      end
      S_RES: begin
        if (st_i.res == 2'd3) begin
          state_d = S_US_R;
        end else if (st_i.res == 2'd0) begin
          cmd_o.set_done  = 1'b1;
          cmd_o.rel_start = 1'b1;
          cmd_o.rel_trim  = st_i.strip_tail;
          if (st_i.strip_tail ? st_i.body_zero : st_i.cnt_zero) begin
            state_d = after_has;
          end else begin
            state_d = S_REL_RD;
            ret_d   = after_has;
          end
        end else begin
          state_d = after_has;
        end
      end
      S_US_R: begin
        if (st_i.emit_ok) begin
          cmd_o.emit      = 1'b1;
          cmd_o.set_done  = 1'b1;
          cmd_o.rel_start = 1'b1;
          cmd_o.rel_trim  = st_i.strip_tail;
          if (st_i.strip_tail ? st_i.body_zero : st_i.cnt_zero) begin
            state_d = after_has;
          end else begin
            state_d = S_REL_RD;
            ret_d   = after_has;
          end
        end
      end
      // character not held for the device-name test
      S_CPART: begin
        if (st_i.strip_tail && st_i.s_dotsp) begin
          if (st_i.full) begin
            cmd_o.rel_start = 1'b1;
            cmd_o.rel_ovf   = 1'b1;
            state_d         = S_REL_RD;
            ret_d           = S_PUSH_C;
          end else begin
            state_d = S_PUSH_C;
          end
        end else begin
          cmd_o.rel_start = 1'b1;
          if (st_i.cnt_zero) begin
            state_d = S_EMIT_S;
          end else begin
            state_d = S_REL_RD;
            ret_d   = S_EMIT_S;
          end
        end
      end
      S_PUSH_C: begin
        cmd_o.push = 1'b1;
        state_d    = after_has;
      end
      S_EMIT_S: begin
        cmd_o.src = SRC_CHAR;
        if (st_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          state_d    = after_has;
        end
      end
      S_LAST: begin
        if (st_i.open && st_i.fix_reserved && st_i.res_tail) begin
          state_d = S_US_L;
        end else begin
          cmd_o.rel_start = 1'b1;
          cmd_o.rel_trim  = st_i.strip_tail;
          if (st_i.strip_tail ? st_i.body_zero : st_i.cnt_zero) begin
            state_d = S_EMPTY;
          end else begin
            state_d = S_REL_RD;
            ret_d   = S_EMPTY;
          end
        end
      end
      S_US_L: begin
        if (st_i.emit_ok) begin
          cmd_o.emit      = 1'b1;
          cmd_o.rel_start = 1'b1;
          cmd_o.rel_trim  = st_i.strip_tail;
          if (st_i.strip_tail ? st_i.body_zero : st_i.cnt_zero) begin
            state_d = S_EMPTY;
          end else begin
            state_d = S_REL_RD;
            ret_d   = S_EMPTY;
          end
        end
      end
      S_EMPTY: begin
        state_d = (!st_i.emitted_any && st_i.fix_empty) ? S_US_E : S_END;
      end
      S_US_E: begin
        if (st_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          state_d    = S_END;
        end
      end
      S_END: begin
        cmd_o.src = SRC_END;
        if (st_i.emitted_step) begin
          state_d = S_FIN;
        end else if (st_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          state_d    = S_FIN;
        end
      end
      // hand the staged result over, tagged last at the end of a name
      S_FIN: begin
        if (!st_i.stage_full) begin
          state_d = S_IDLE;
        end else if (st_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_REL_RD: begin
        if (st_i.rem_zero) begin
          state_d = ret_q;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_REL_EM;
        end
      end
      S_REL_EM: begin
        cmd_o.src = SRC_STORE;
        if (st_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          state_d    = S_REL_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

endmodule

// ===== design/fcs_dpath.sv =====
// ----------------------------------------------------------------------------
// fcs_dpath
// Datapath: config registers, substitution, pending memory, device-name
// matcher, one-result stage and output register.
// ----------------------------------------------------------------------------
module fcs_dpath #(
  parameter int unsigned PENDING_DEPTH = fcs_pkg::PENDING_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fcs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fcs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic [fcs_pkg::CP_W-1:0]         in_point_i,
  input  logic                             in_has_i,
  input  logic                             in_last_i,
  input  fcs_pkg::dp_cmd_t                 cmd_i,
  output fcs_pkg::dp_status_t              st_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [fcs_pkg::CP_W-1:0]         out_point_o,
  output logic                             out_char_o,
  output logic                             out_last_o,
  output logic                             out_ovf_o
);
  import fcs_pkg::*;

  localparam int unsigned PW = $clog2(PENDING_DEPTH);
  localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C  = CW'(PENDING_DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(PENDING_DEPTH - 1);

  // configuration
  logic [1:0] lvl_q;
  logic       fix_empty_q, strip_q, fixr_q, keep_q;

  // current item
  logic [CP_W-1:0] s_q;
  logic            has_q, last_q, qph_q;

  // pending store, circular
  logic [CP_W-1:0] mem_q [PENDING_DEPTH];
  logic [CP_W-1:0] rdata_q;
  logic [PW-1:0]   head_q, wr_ptr;
  logic [SW-1:0]   tail_sum;
  logic [CW-1:0]   cnt_q, trail_q, rem_q;
  logic            rel_ovf_q;

  // device-name matcher
  logic                open_q;
  logic [NUM_DEV-1:0]  mask_q, step_ok, alive, dot_hit, name_done, tail_hit;
  logic [1:0]          res_q, res_next;

  logic any_q, step_q;

  // stage and output
  logic [CP_W-1:0] stage_point_q, out_point_q;
  logic            stage_char_q, stage_ovf_q, stage_full_q;
  logic            out_valid_q, out_char_q, out_last_q, out_ovf_q;

  logic            out_free, emit_ok, name_rst;
  logic [CP_W-1:0] em_point;
  logic            em_char, em_ovf;

  assign out_free = !out_valid_q || out_ready_i;
  assign emit_ok  = !stage_full_q || out_free;
  assign name_rst = cmd_i.flush && last_q;

  assign tail_sum = SW'(head_q) + SW'(cnt_q);
  assign wr_ptr   = (tail_sum >= SW'(PENDING_DEPTH)) ? PW'(tail_sum - SW'(PENDING_DEPTH))
                                                    : PW'(tail_sum);

  // next character against every device name; position is the fill count
  always_comb begin
    for (int unsigned p = 0; p < NUM_DEV; p++) begin
      if (cnt_q < CW'(DEV_LEN[p])) begin
        step_ok[p] = pat_ok(p, cnt_q[1:0], s_q);
        dot_hit[p] = 1'b0;
      end else begin
        step_ok[p] = is_dotsp(s_q);
        dot_hit[p] = (s_q == CH_DOT);
      end
      alive[p]     = mask_q[p] && step_ok[p];
      name_done[p] = (cnt_q >= CW'(DEV_LEN[p] - 3'd1));
      tail_hit[p]  = mask_q[p] && (cnt_q >= CW'(DEV_LEN[p]));
    end
    if (|(alive & dot_hit))        res_next = 2'd3;
    else if (|(alive & name_done)) res_next = 2'd2;
    else if (|alive)               res_next = 2'd1;
    else                           res_next = 2'd0;
  end

  always_comb begin
    case (cmd_i.src)
      SRC_UNDERSCORE: begin em_point = CH_US;   em_char = 1'b1; em_ovf = 1'b0;      end
      SRC_CHAR:       begin em_point = s_q;     em_char = 1'b1; em_ovf = 1'b0;      end
      SRC_STORE:      begin em_point = rdata_q; em_char = 1'b1; em_ovf = rel_ovf_q; end
      SRC_END:        begin em_point = '0;      em_char = 1'b0; em_ovf = 1'b0;      end
      default:        begin em_point = '0;      em_char = 1'b0; em_ovf = 1'b0;      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) mem_q[wr_ptr] <= s_q;
    if (cmd_i.rd)   rdata_q       <= mem_q[head_q];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) s_q <= subst(in_point_i, lvl_q, keep_q, qph_q);
    if (cmd_i.push && cmd_i.match) res_q <= res_next;
    if (cmd_i.rel_start) rel_ovf_q <= cmd_i.rel_ovf;
    if (cmd_i.emit) begin
      stage_point_q <= em_point;
      stage_char_q  <= em_char;
      stage_ovf_q   <= em_ovf;
    end
    if ((cmd_i.emit && stage_full_q) || cmd_i.flush) begin
      out_point_q <= stage_char_q ? stage_point_q : '0;
      out_char_q  <= stage_char_q;
      out_ovf_q   <= stage_ovf_q;
      out_last_q  <= cmd_i.flush && last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q        <= 2'd0;
      fix_empty_q  <= 1'b0;
      strip_q      <= 1'b0;
      fixr_q       <= 1'b0;
      keep_q       <= 1'b0;
      has_q        <= 1'b0;
      last_q       <= 1'b0;
      qph_q        <= 1'b0;
      head_q       <= '0;
      cnt_q        <= '0;
      trail_q      <= '0;
      rem_q        <= '0;
      open_q       <= 1'b1;
      mask_q       <= '1;
      any_q        <= 1'b0;
      step_q       <= 1'b0;
      stage_full_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SUB_LEVEL:    lvl_q       <= cfg_wdata_i;
          REG_FIX_EMPTY:    fix_empty_q <= cfg_wdata_i[0];
          REG_STRIP_TAIL:   strip_q     <= cfg_wdata_i[0];
          REG_FIX_RESERVED: fixr_q      <= cfg_wdata_i[0];
          REG_KEEP_COLON:   keep_q      <= cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (cmd_i.load) begin
        has_q  <= in_has_i;
        last_q <= in_last_i;
        step_q <= 1'b0;
        // quote alternation only advances while substitution is on
        if (in_has_i && (lvl_q != 2'd0) && (in_point_i == CH_QUOTE)) qph_q <= !qph_q;
      end

      if (cmd_i.push) begin
        cnt_q   <= cnt_q + 1'b1;
        trail_q <= is_dotsp(s_q) ? trail_q + 1'b1 : '0;
        if (cmd_i.match) mask_q <= alive;
      end
      if (cmd_i.rel_start) begin
        rem_q <= cmd_i.rel_trim ? cnt_q - trail_q : cnt_q;
        if (!cmd_i.rel_trim) trail_q <= '0;
      end
      if (cmd_i.rd) begin
        head_q <= (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
        cnt_q  <= cnt_q - 1'b1;
        rem_q  <= rem_q - 1'b1;
      end
      if (cmd_i.set_done) open_q <= 1'b0;

      if (cmd_i.emit) begin
        step_q       <= 1'b1;
        stage_full_q <= 1'b1;
        if (em_char) any_q <= 1'b1;
      end

      if ((cmd_i.emit && stage_full_q) || cmd_i.flush) out_valid_q <= 1'b1;
      else if (out_ready_i)                            out_valid_q <= 1'b0;
      if (cmd_i.flush) stage_full_q <= 1'b0;

      if (name_rst) begin
        qph_q   <= 1'b0;
        head_q  <= '0;
        cnt_q   <= '0;
        trail_q <= '0;
        open_q  <= 1'b1;
        mask_q  <= '1;
        any_q   <= 1'b0;
      end
    end
  end

  always_comb begin
    st_o              = '0;
    st_o.has          = has_q;
    st_o.last         = last_q;
    st_o.open         = open_q;
    st_o.fix_reserved = fixr_q;
    st_o.strip_tail   = strip_q;
    st_o.fix_empty    = fix_empty_q;
    st_o.full         = (cnt_q >= DEPTH_C);
    st_o.cnt_zero     = (cnt_q == '0);
    st_o.body_zero    = (cnt_q == trail_q);
    st_o.rem_zero     = (rem_q == '0);
    st_o.s_dotsp      = is_dotsp(s_q);
    st_o.res          = res_q;
    st_o.res_tail     = |tail_hit;
    st_o.emitted_any  = any_q;
    st_o.emitted_step = step_q;
    st_o.emit_ok      = emit_ok;
    st_o.stage_full   = stage_full_q;
    st_o.out_free     = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_point_o = out_point_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_ovf_o   = out_ovf_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_C)
    else $error("pending count beyond store depth");

  a_trail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trail_q <= cnt_q)
    else $error("trailing run longer than held run");

  a_rd_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> (cnt_q != '0) && (rem_q != '0) && !cmd_i.push)
    else $error("pending store read while nothing left to release");

  a_name_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    name_rst |=> (cnt_q == '0) && open_q && !stage_full_q && out_last_o)
    else $error("per-name state not cleared after last result");

endmodule

// ===== design/filename_char_sanitizer_unit.sv =====
// ----------------------------------------------------------------------------
// filename_char_sanitizer_unit
// Streaming file-name sanitizer: one code point in, corrected name out.
// ----------------------------------------------------------------------------
// A character that passes straight through goes from acceptance to its result
// sitting in the output register through accept, decide, emit and hand-off
// steps, and the next item is accepted once that hand-off is done. A
// transaction with neither character nor last goes through accept, decide and
// hand-off. A character held for the device-name test is pushed and then gets
// its verdict, plus an underscore emit when the verdict inserts the prefix; a
// character held for dot/space stripping is pushed and then handed off. A
// character that closes the device-name test on arrival (prefixing off or
// store full) passes a further decision step before it is emitted. Releasing
// held characters reads and then emits each one in turn before leaving the
// release loop, set by the single registered read port of the pending memory.
// Closing a name goes through prefix test and release, empty-name test and end
// marker, plus an emit for each underscore inserted there. Output back-pressure
// stalls the sequencer in place. The pending memory needs no clearing pass
// after reset; only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module filename_char_sanitizer_unit #(
  parameter int unsigned PENDING_DEPTH = fcs_pkg::PENDING_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [fcs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fcs_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [fcs_pkg::TDATA_W-1:0]       s_axis_tdata,  // [20:0] code_point
  input  logic [0:0]                        s_axis_tuser,  // [0] has_char
  input  logic                              s_axis_tlast,
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [fcs_pkg::TDATA_W-1:0]       m_axis_tdata,  // [20:0] out_point
  output logic [1:0]                        m_axis_tuser,  // [0] out_valid, [1] overflow
  output logic                              m_axis_tlast
);
  import fcs_pkg::*;

  dp_cmd_t         cmd;
  dp_status_t      st;
  logic [CP_W-1:0] out_point;
  logic            out_char, out_ovf;

  fcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  fcs_dpath #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_point_i  (s_axis_tdata[CP_W-1:0]),
    .in_has_i    (s_axis_tuser[0]),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_point_o (out_point),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast),
    .out_ovf_o   (out_ovf)
  );

  assign m_axis_tdata = {{(TDATA_W-CP_W){1'b0}}, out_point};
  assign m_axis_tuser = {out_ovf, out_char};

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stream test of the file-name sanitizer. Names go in one code point per
// transaction; a scoreboard works out each corrected name from its own model
// of substitution, device-name prefixing, tail stripping and store overflow,
// and compares every output transaction field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import fcs_pkg::*;

  localparam int unsigned HOLD_DEPTH = PENDING_DEPTH_DEF;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned SETTLE = 24;
  localparam int unsigned PHASE_ITEMS = 37;
  localparam int unsigned NUM_PHASES = 7;

  localparam logic [CP_W-1:0] CP_LT     = 21'h3C;
  localparam logic [CP_W-1:0] CP_GT     = 21'h3E;
  localparam logic [CP_W-1:0] CP_COLON  = 21'h3A;
  localparam logic [CP_W-1:0] CP_STAR   = 21'h2A;
  localparam logic [CP_W-1:0] CP_QMARK  = 21'h3F;
  localparam logic [CP_W-1:0] CP_BAR    = 21'h7C;
  localparam logic [CP_W-1:0] CP_SLASH  = 21'h2F;
  localparam logic [CP_W-1:0] CP_BSLASH = 21'h5C;

  localparam logic [CP_W-1:0] BAD_PUNCT [9] = '{CP_LT, CP_GT, CP_COLON, CP_STAR,
    CP_QMARK, CP_BAR, CH_QUOTE, CP_SLASH, CP_BSLASH};

  // glyphs for control codes 1..31, entry 0 is code 1
  localparam logic [15:0] CTL_GLYPH [31] = '{
    16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022, 16'h25D8,
    16'h25CB, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C, 16'h25BA,
    16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8, 16'h2191,
    16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC};

  typedef struct packed {
    logic [CP_W-1:0] point;
    logic            valid;
    logic            last;
    logic            ovf;
  } name_out_t;

  typedef enum int {DEV_NONE, DEV_PARTIAL, DEV_NAME, DEV_NAME_DOT} dev_verdict_e;
  typedef enum int {CLOSE_ON_CHAR, CLOSE_APART, CLOSE_NONE} close_e;

  class name_board;
    logic [1:0]      level;
    bit              fix_empty, strip_tail, fix_reserved, keep_colon;
    bit              quote_odd;
    bit              dev_open = 1'b1;
    bit              any_out;
    logic [CP_W-1:0] held[$];
    name_out_t       step_q[$];
    name_out_t       want_q[$];
    int unsigned     errors;

    static function string dev_name(int d);
      case (d)
        0: return "CON";
        1: return "PRN";
        2: return "AUX";
        3: return "NUL";
        4: return "COM#";
        default: return "LPT#";
      endcase
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SUB_LEVEL:    level = val;
        REG_FIX_EMPTY:    fix_empty = val[0];
        REG_STRIP_TAIL:   strip_tail = val[0];
        REG_FIX_RESERVED: fix_reserved = val[0];
        REG_KEEP_COLON:   keep_colon = val[0];
        default: ;
      endcase
    endfunction

    function int outstanding();
      return want_q.size();
    endfunction

    function logic [CP_W-1:0] map_char(logic [CP_W-1:0] c);
      bit              sym;
      logic [CP_W-1:0] r;
      sym = level > 2'd1;
      r   = c;
      if (level == 2'd0) return c;
      case (c)
        CP_LT:     r = sym ? 21'h00AB : CH_US;
        CP_GT:     r = sym ? 21'h00BB : CH_US;
        CP_COLON:  if (!keep_colon) r = sym ? ((level == 2'd2) ? 21'h2026 : 21'h0589) : CH_US;
        CP_STAR:   r = sym ? ((level == 2'd2) ? 21'h00A4 : 21'h0589) : CH_US;
        CP_QMARK:  r = sym ? 21'h00BF : CH_US;
        CP_BAR:    r = sym ? 21'h00A6 : CH_US;
        CP_SLASH:  r = sym ? 21'h2044 : CH_US;
        CP_BSLASH: r = sym ? 21'h00AC : CH_US;
        CH_QUOTE: begin
          r = sym ? (quote_odd ? 21'h201D : 21'h201C) : CH_US;
          quote_odd = !quote_odd;
        end
        default: begin
          if (c >= 21'd1 && c < 21'd32)
            r = sym ? {5'd0, CTL_GLYPH[int'(c[4:0]) - 1]} : CH_US;
        end
      endcase
      return r;
    endfunction

    // how far the held characters go toward a device name
    function dev_verdict_e dev_verdict();
      dev_verdict_e    best, r;
      int              n, len;
      bit              ok;
      string           nm;
      logic [CP_W-1:0] c;
      best = DEV_NONE;
      n = held.size();
      for (int p = 0; p < 6; p++) begin
        nm  = dev_name(p);
        len = nm.len();
        ok  = 1'b1;
        for (int i = 0; i < len && i < n; i++) begin
          c = held[i];
          if (nm[i] == "#") begin
            if (c < "0" || c > "9") ok = 1'b0;
          end else begin
            if (c >= "a" && c <= "z") c = c - 21'h20;
            if (c != {13'd0, nm[i]}) ok = 1'b0;
          end
          if (!ok) break;
        end
        if (ok) begin
          if (n < len) begin
            if (best < DEV_PARTIAL) best = DEV_PARTIAL;
          end else begin
            r = DEV_NAME;
            for (int i = len; i < n; i++) begin
              if (held[i] == CH_DOT) begin
                r = DEV_NAME_DOT;
                break;
              end
              if (held[i] != CH_SP) begin
                r = DEV_NONE;
                break;
              end
            end
            if (best < r) best = r;
          end
        end
      end
      return best;
    endfunction

    function void put(logic [CP_W-1:0] pt, bit vld, bit ovf);
      name_out_t o;
      o.point = vld ? pt : '0;
      o.valid = vld;
      o.last  = 1'b0;
      o.ovf   = ovf;
      if (vld) any_out = 1'b1;
      step_q.insert(step_q.size(), o);
    endfunction

    // emit held run; with trim a trailing dot/space run stays held or is dropped
    function void flush_held(bit trim, bit drop, bit ovf);
      int cut, n;
      n = held.size();
      cut = n;
      if (trim)
        while (cut > 0 && (held[cut-1] == CH_DOT || held[cut-1] == CH_SP)) cut--;
      for (int i = 0; i < cut; i++) put(held[i], 1'b1, ovf);
      if (drop || cut == n) held.delete();
      else repeat (cut) void'(held.pop_front());
    endfunction

    function void take_item(logic [CP_W-1:0] cp, bit has, bit lst);
      logic [CP_W-1:0] s;
      bit              taken;
      dev_verdict_e    v;
      step_q.delete();
      if (has) begin
        s = map_char(cp);
        taken = 1'b0;
        if (dev_open && !fix_reserved) begin
          dev_open = 1'b0;
          flush_held(strip_tail, 1'b0, 1'b0);
        end
        if (dev_open) begin
          if (held.size() >= HOLD_DEPTH) begin
            flush_held(1'b0, 1'b0, 1'b1);
            dev_open = 1'b0;
          end else begin
            held.insert(held.size(), s);
            taken = 1'b1;
            v = dev_verdict();
            if (v == DEV_NAME_DOT) begin
              put(CH_US, 1'b1, 1'b0);
              dev_open = 1'b0;
              flush_held(strip_tail, 1'b0, 1'b0);
            end else if (v == DEV_NONE) begin
              dev_open = 1'b0;
              flush_held(strip_tail, 1'b0, 1'b0);
            end
          end
        end
        if (!taken) begin
          if (strip_tail && (s == CH_DOT || s == CH_SP)) begin
            if (held.size() >= HOLD_DEPTH) flush_held(1'b0, 1'b0, 1'b1);
            held.insert(held.size(), s);
          end else begin
            flush_held(1'b0, 1'b0, 1'b0);
            put(s, 1'b1, 1'b0);
          end
        end
      end
      if (lst) begin
        if (dev_open && fix_reserved && dev_verdict() >= DEV_NAME) put(CH_US, 1'b1, 1'b0);
        flush_held(strip_tail, 1'b1, 1'b0);
        if (!any_out && fix_empty) put(CH_US, 1'b1, 1'b0);
        if (step_q.size() == 0) put('0, 1'b0, 1'b0);
        step_q[step_q.size()-1].last = 1'b1;
        quote_odd = 1'b0;
        held.delete();
        dev_open = 1'b1;
        any_out = 1'b0;
      end
      foreach (step_q[i]) want_q.insert(want_q.size(), step_q[i]);
    endfunction

    function void check_out(name_out_t got);
      name_out_t want;
      if (want_q.size() == 0) begin
        errors++;
        $display("%0t: expected no output, got point=%h valid=%b last=%b ovf=%b", $time,
                 got.point, got.valid, got.last, got.ovf);
        return;
      end
      want = want_q.pop_front();
      if (got.point !== want.point) begin
        errors++;
        $display("%0t: out_point expected %h got %h", $time, want.point, got.point);
      end
      if (got.valid !== want.valid) begin
        errors++;
        $display("%0t: out_valid expected %b got %b", $time, want.valid, got.valid);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: out_last expected %b got %b", $time, want.last, got.last);
      end
      if (got.ovf !== want.ovf) begin
        errors++;
        $display("%0t: overflow expected %b got %b", $time, want.ovf, got.ovf);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [TDATA_W-1:0]    m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  name_board   board;
  bit          gaps_on;
  int unsigned fed;
  int unsigned quiet;
  int unsigned stall_left;

  filename_char_sanitizer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // output sink: random stall bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_out('{point: m_axis_tdata[CP_W-1:0], valid: m_axis_tuser[0],
                        last: m_axis_tlast, ovf: m_axis_tuser[1]});
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [CP_W-1:0] rand_cp();
    return CP_W'($urandom_range(0, 21'h1FFFFF));
  endfunction

  function automatic logic [CP_W-1:0] any_case(byte ch);
    if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1)) ch = ch + 8'h20;
    return {13'd0, ch};
  endfunction

  function automatic logic [CP_W-1:0] pick_char();
    string letters;
    letters = "CONPRUXLMTA";
    case ($urandom_range(0, 12))
      0, 1:  return BAD_PUNCT[$urandom_range(0, 8)];
      2:     return CP_W'($urandom_range(0, 31));
      3, 4:  return any_case(letters[$urandom_range(0, letters.len() - 1)]);
      5:     return CP_W'($urandom_range("0", "9"));
      6:     return CH_SP;
      7:     return CH_DOT;
      8:     return CP_W'($urandom_range(21'h20, 21'h7E));
      9:     return CP_W'($urandom_range(0, 21'hFFFF));
      10:    return CP_W'($urandom_range(21'h100000, 21'h10FFFF));
      11:    return CP_W'($urandom_range(21'h110000, 21'h1FFFFF));
      default: return CP_W'($urandom_range(0, 21'h10FFFF));
    endcase
  endfunction

  task automatic send(input logic [CP_W-1:0] cp, input bit has, input bit lst);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(TDATA_W-CP_W){1'b0}}, cp};
    s_axis_tuser  <= has;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.take_item(cp, has, lst);
    fed++;
    @(negedge clk_i);
  endtask

  task automatic send_chars(input logic [CP_W-1:0] nm[$], input close_e how);
    int n;
    n = nm.size();
    for (int i = 0; i < n; i++) begin
      // a transaction with neither character nor last must change nothing
      if ($urandom_range(0, 15) == 0) send(rand_cp(), 1'b0, 1'b0);
      send(nm[i], 1'b1, how == CLOSE_ON_CHAR && i == n - 1);
    end
    if (how == CLOSE_APART || (how == CLOSE_ON_CHAR && n == 0))
      send(rand_cp(), 1'b0, 1'b1);
  endtask

  task automatic send_text(input string t, input close_e how);
    logic [CP_W-1:0] nm[$];
    for (int i = 0; i < t.len(); i++) nm.insert(nm.size(), {13'd0, t[i]});
    send_chars(nm, how);
  endtask

  task automatic send_device_name();
    logic [CP_W-1:0] nm[$];
    string           base;
    int              tail;
    base = name_board::dev_name($urandom_range(0, 5));
    for (int i = 0; i < base.len(); i++) begin
      if (base[i] == "#") nm.insert(nm.size(), CP_W'($urandom_range("0", "9")));
      else nm.insert(nm.size(), any_case(base[i]));
    end
    if ($urandom_range(0, 4) == 0) nm[$urandom_range(0, nm.size() - 1)] = pick_char();
    if ($urandom_range(0, 5) == 0) nm.delete(nm.size() - 1);
    repeat ($urandom_range(0, 3)) nm.insert(nm.size(), CH_SP);
    tail = $urandom_range(0, 4);
    case (tail)
      1: begin
        nm.insert(nm.size(), CH_DOT);
        repeat ($urandom_range(0, 3)) nm.insert(nm.size(), pick_char());
      end
      2: repeat ($urandom_range(1, 3)) nm.insert(nm.size(), pick_char());
      3: repeat ($urandom_range(1, 3))
           nm.insert(nm.size(), $urandom_range(0, 1) ? CH_DOT : CH_SP);
      default: ;
    endcase
    send_chars(nm, (tail == 4) ? CLOSE_APART : CLOSE_ON_CHAR);
  endtask

  task automatic send_plain_name();
    logic [CP_W-1:0] nm[$];
    repeat ($urandom_range(0, 8)) nm.insert(nm.size(), pick_char());
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3))
        nm.insert(nm.size(), $urandom_range(0, 1) ? CH_DOT : CH_SP);
    send_chars(nm, $urandom_range(0, 5) == 0 ? CLOSE_APART : CLOSE_ON_CHAR);
  endtask

  // device name followed by a run of spaces that can fill the pending store
  task automatic send_full_device_run();
    logic [CP_W-1:0] nm[$];
    string           base;
    base = name_board::dev_name($urandom_range(0, 3));
    for (int i = 0; i < base.len(); i++) nm.insert(nm.size(), any_case(base[i]));
    repeat ($urandom_range(27, 31)) nm.insert(nm.size(), CH_SP);
    nm.insert(nm.size(), pick_char());
    send_chars(nm, CLOSE_ON_CHAR);
  endtask

  // long dot/space run meant for tail stripping
  task automatic send_full_tail_run();
    logic [CP_W-1:0] nm[$];
    nm.insert(nm.size(), any_case("A"));
    repeat ($urandom_range(30, 36))
      nm.insert(nm.size(), $urandom_range(0, 1) ? CH_DOT : CH_SP);
    if ($urandom_range(0, 1)) nm.insert(nm.size(), pick_char());
    send_chars(nm, CLOSE_ON_CHAR);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (board.outstanding() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // holds the write enable high; the caller lowers it after the last write
  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    board.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic cfg_all(input logic [1:0] lvl, input bit fe, input bit st,
                         input bit fr, input bit kc);
    cfg_put(REG_SUB_LEVEL, lvl);
    cfg_put(REG_FIX_EMPTY, {1'b0, fe});
    cfg_put(REG_STRIP_TAIL, {1'b0, st});
    cfg_put(REG_FIX_RESERVED, {1'b0, fr});
    cfg_put(REG_KEEP_COLON, {1'b0, kc});
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned goal;
    board         = new();
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    gaps_on       = 1'b1;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: every punctuation substitution, quote pairing, field extremes, device names
    cfg_all(2'd2, 1'b1, 1'b1, 1'b1, 1'b0);
    send_text("<>:*?|/\\\"\"", CLOSE_ON_CHAR);
    send(21'h01, 1'b1, 1'b0);
    send(21'h1F, 1'b1, 1'b0);
    send(21'h00, 1'b1, 1'b0);
    send(21'h1FFFFF, 1'b1, 1'b1);
    send_text("nuL.", CLOSE_ON_CHAR);
    send_text("Lp", CLOSE_NONE);
    send(rand_cp(), 1'b0, 1'b0);
    send_text("T0", CLOSE_ON_CHAR);
    send(rand_cp(), 1'b0, 1'b1);
    // device test still open when prefixing is switched off
    send_text("CO", CLOSE_NONE);
    wait_idle();
    cfg_put(REG_FIX_RESERVED, '0);
    cfg_we_i <= 1'b0;
    send_text("N", CLOSE_ON_CHAR);

    goal = fed;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: cfg_all(2'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        1: cfg_all(2'd3, 1'b1, 1'b1, 1'b1, 1'b1);
        2: cfg_all(2'd1, 1'b0, 1'b1, 1'b1, 1'b0);
        3: cfg_all(2'd2, 1'b1, 1'b1, 1'b0, 1'b1);
        default: cfg_all(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
      endcase
      goal += PHASE_ITEMS;
      gaps_on = (ph < NUM_PHASES - 1);
      if (ph == 1) send_full_device_run();
      if (ph == 3) send_full_tail_run();
      while (fed < goal) begin
        gaps_on = (ph < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 59))
          0:       send_full_device_run();
          1:       send_full_tail_run();
          2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20, 21, 22, 23:
                   send_device_name();
          default: send_plain_name();
        endcase
      end
    end

    s_axis_tvalid <= 1'b0;
    while (board.outstanding() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (board.errors == 0 && board.outstanding() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
design/fcs_pkg.sv
design/fcs_ctrl.sv
design/fcs_dpath.sv
design/filename_char_sanitizer_unit.sv
tb/tb.sv
